// ===== hw/rtl/sha1_pkg.sv =====
// Package with the constants and types shared by the SHA-1 digest modules.
package sha1_pkg;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam int unsigned ROUNDS = 80;
	localparam logic [2:0] LAST_INDEX = 3'd4;

	typedef struct packed {
		logic put;
		logic [7:0] byte_val;
		logic count_up;
		logic save_len;
		logic put_len;
		logic start;
		logic reset_chain;
	} sha1_cmd_t;

	typedef struct packed {
		logic busy;
		logic [5:0] pos;
	} sha1_stat_t;
endpackage

// ===== hw/rtl/sha1_if.sv =====
// Valid/ready channel interface carrying one word of a generic payload type.
interface sha1_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/sha1_message_digest.sv =====
// Top level of the streaming SHA-1 message digest.
// One word carries a message byte and an end mark; bytes are taken one per cycle while
// the input is ready. After the last byte of a full 64-byte block the input is not ready
// while the single round unit runs its 80 rounds. An end mark pads the message one byte
// per cycle outside compressions, runs one or two more blocks through the round unit and
// then offers the five digest words H0 to H4 on the output, one per accepted output word.
module sha1_message_digest (
	input logic clk,
	input logic arst_n,
	sha1_if.sink in_ch,
	sha1_if.source out_ch
);
	sha1_pkg::sha1_cmd_t cmd;
	sha1_pkg::sha1_stat_t stat;
	logic [31:0] chain [5];

	sha1_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cmd(cmd), .stat(stat), .chain(chain)
	);

	sha1_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .chain(chain)
	);
endmodule

// ===== hw/rtl/sha1_datapath.sv =====
// SHA-1 datapath: block buffer, length counter, round engine and chain values.
module sha1_datapath (
	input logic clk,
	input logic arst_n,
	input sha1_pkg::sha1_cmd_t cmd,
	output sha1_pkg::sha1_stat_t stat,
	output logic [31:0] chain [5]
);
	logic [31:0] w_q [16];
	logic [63:0] count_q;
	logic [63:0] len_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0] round_q;
	logic busy_q;
	logic [5:0] pos;
	logic [31:0] wt, f, k, tmp, wnew;

	assign pos = count_q[8:3];
	assign stat.busy = busy_q;
	assign stat.pos = pos;
	assign chain = h_q;

	assign wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign wt = (round_q < 7'd16) ? w_q[0] : {wnew[30:0], wnew[31]};

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K3;
		end
	end
	assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + wt + k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q <= '0;
			busy_q <= 1'b0;
			round_q <= '0;
			h_q[0] <= sha1_pkg::H0;
			h_q[1] <= sha1_pkg::H1;
			h_q[2] <= sha1_pkg::H2;
			h_q[3] <= sha1_pkg::H3;
			h_q[4] <= sha1_pkg::H4;
		end else begin
			if (cmd.count_up) begin
				count_q <= count_q + 64'd8;
			end
			if (cmd.save_len) begin
				len_q <= count_q;
			end
			if (cmd.start) begin
				busy_q <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 7'd1;
				if (round_q == 7'(sha1_pkg::ROUNDS - 1)) begin
					busy_q <= 1'b0;
					h_q[0] <= h_q[0] + tmp;
					h_q[1] <= h_q[1] + a_q;
					h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
					h_q[3] <= h_q[3] + c_q;
					h_q[4] <= h_q[4] + d_q;
				end
			end
			if (cmd.reset_chain) begin
				count_q <= '0;
				h_q[0] <= sha1_pkg::H0;
				h_q[1] <= sha1_pkg::H1;
				h_q[2] <= sha1_pkg::H2;
				h_q[3] <= sha1_pkg::H3;
				h_q[4] <= sha1_pkg::H4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (busy_q) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= tmp;
		end
	end

	// The message schedule is a shift line: word 0 is the round word in rounds 0-15.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wt;
		end else if (cmd.put_len) begin
			w_q[14] <= len_q[63:32];
			w_q[15] <= len_q[31:0];
		end else if (cmd.put) begin
			case (pos[1:0])
				2'd0: w_q[pos[5:2]] <= {cmd.byte_val, 24'd0};
				2'd1: w_q[pos[5:2]][23:16] <= cmd.byte_val;
				2'd2: w_q[pos[5:2]][15:8] <= cmd.byte_val;
				default: w_q[pos[5:2]][7:0] <= cmd.byte_val;
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q) else $error("compression started while busy");
	a_no_put_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !cmd.put && !cmd.count_up) else $error("byte written during rounds");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> round_q < 7'(sha1_pkg::ROUNDS)) else $error("round counter out of range");
endmodule

// ===== hw/rtl/sha1_control.sv =====
// SHA-1 controller: accepts words, sequences padding, compression and digest output.
module sha1_control (
	input logic clk,
	input logic arst_n,
	sha1_if.sink in_ch,
	sha1_if.source out_ch,
	output sha1_pkg::sha1_cmd_t cmd,
	input sha1_pkg::sha1_stat_t stat,
	input logic [31:0] chain [5]
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_WAIT = 7'b0000010,
		S_PAD80 = 7'b0000100,
		S_ZERO = 7'b0001000,
		S_FLUSH = 7'b0010000,
		S_LEN = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic last_q, close_q, after_q;
	logic [2:0] idx_q;
	logic acc, outacc;

	assign in_ch.ready = (state_q == S_IDLE);
	assign acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.data.digest_word = chain[idx_q];
	assign out_ch.data.word_index = idx_q;
	assign out_ch.data.last_word = (idx_q == sha1_pkg::LAST_INDEX);
	assign outacc = out_ch.valid && out_ch.ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.put = in_ch.data.has_byte;
					cmd.count_up = in_ch.data.has_byte;
					cmd.byte_val = in_ch.data.data_byte;
					if (in_ch.data.has_byte && stat.pos == 6'd63) begin
						cmd.start = 1'b1;
						state_d = S_WAIT;
					end else if (in_ch.data.last) begin
						state_d = S_PAD80;
					end
				end
			end
			S_WAIT: begin
				if (!stat.busy) begin
					if (after_q) begin
						state_d = S_OUT;
					end else if (close_q) begin
						state_d = S_ZERO;
					end else if (last_q) begin
						state_d = S_PAD80;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_PAD80: begin
				cmd.put = 1'b1;
				cmd.count_up = 1'b1;
				cmd.save_len = 1'b1;
				cmd.byte_val = sha1_pkg::PAD_BYTE;
				if (stat.pos == 6'd63) begin
					cmd.start = 1'b1;
					state_d = S_FLUSH;
				end else begin
					state_d = S_ZERO;
				end
			end
			S_ZERO: begin
				// Zero fill stops at the length field; a pad byte past it first flushes a block.
				if (stat.pos == sha1_pkg::LEN_POS) begin
					state_d = S_LEN;
				end else begin
					cmd.put = 1'b1;
					cmd.count_up = 1'b1;
					cmd.byte_val = 8'd0;
					if (stat.pos == 6'd63) begin
						cmd.start = 1'b1;
						state_d = S_FLUSH;
					end
				end
			end
			S_FLUSH: state_d = S_WAIT;
			S_LEN: begin
				cmd.put_len = 1'b1;
				cmd.start = 1'b1;
				state_d = S_WAIT;
			end
			S_OUT: begin
				if (outacc && idx_q == sha1_pkg::LAST_INDEX) begin
					cmd.reset_chain = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
			close_q <= 1'b0;
			after_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && acc) begin
				last_q <= in_ch.data.last;
				close_q <= 1'b0;
				after_q <= 1'b0;
			end
			if (state_q == S_LEN) begin
				after_q <= 1'b1;
			end
			if (state_q == S_FLUSH) begin
				close_q <= 1'b1;
			end
			if (outacc) begin
				idx_q <= (idx_q == sha1_pkg::LAST_INDEX) ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	a_out_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> idx_q <= sha1_pkg::LAST_INDEX) else $error("digest index out of range");
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		outacc && out_ch.data.last_word |=> state_q == S_IDLE)
		else $error("controller not idle after digest");
	a_len_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LEN |-> cmd.start) else $error("length block not compressed");
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming SHA-1 message digest block.
module testbench;
	typedef struct packed {
		logic [7:0] data_byte;
		logic has_byte;
		logic last;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} digest_item_t;

	localparam int unsigned RANDOM_ITEMS = 320;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 250;

	class sha1_scoreboard;
		bit [31:0] chain[5];
		bit [31:0] block_buf[16];
		bit [63:0] msg_bits;
		digest_item_t digest_q[$];
		int unsigned mismatches;
		int unsigned words_checked;
		int unsigned digests_done;

		function new();
			restart();
			foreach (block_buf[i]) block_buf[i] = '0;
			mismatches = 0;
			words_checked = 0;
			digests_done = 0;
		endfunction

		function void restart();
			chain[0] = sha1_pkg::H0;
			chain[1] = sha1_pkg::H1;
			chain[2] = sha1_pkg::H2;
			chain[3] = sha1_pkg::H3;
			chain[4] = sha1_pkg::H4;
			msg_bits = '0;
		endfunction

		function void compress();
			bit [31:0] w[16];
			bit [31:0] a, b, c, d, e, f, k, wt, sum;
			for (int i = 0; i < 16; i++) w[i] = block_buf[i];
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int t = 0; t < sha1_pkg::ROUNDS; t++) begin
				if (t >= 16) begin
					wt = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
					wt = {wt[30:0], wt[31]};
					w[t % 16] = wt;
				end else begin
					wt = w[t];
				end
				if (t < 20) begin
					f = (b & c) | (~b & d);
					k = sha1_pkg::K0;
				end else if (t < 40) begin
					f = b ^ c ^ d;
					k = sha1_pkg::K1;
				end else if (t < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = sha1_pkg::K2;
				end else begin
					f = b ^ c ^ d;
					k = sha1_pkg::K3;
				end
				sum = {a[26:0], a[31:27]} + f + e + wt + k;
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = sum;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void place_byte(int unsigned pos, bit [7:0] val);
			int unsigned idx;
			int unsigned sh;
			idx = pos / 4;
			sh = (3 - pos % 4) * 8;
			if (pos % 4 == 0)
				block_buf[idx] = {val, 24'h0};
			else
				block_buf[idx] |= 32'(val) << sh;
		endfunction

		function void note_input(msg_item_t it);
			int unsigned pos;
			bit [63:0] len;
			digest_item_t exp_word;
			if (it.has_byte) begin
				pos = int'(msg_bits[8:3]);
				place_byte(pos, it.data_byte);
				msg_bits += 64'd8;
				if (pos == 63) compress();
			end
			if (!it.last) return;
			len = msg_bits;
			pos = int'(len[8:3]);
			place_byte(pos, sha1_pkg::PAD_BYTE);
			pos++;
			if (pos > sha1_pkg::LEN_POS) begin
				while (pos < 64) begin
					place_byte(pos, 8'h00);
					pos++;
				end
				compress();
				pos = 0;
			end
			while (pos < sha1_pkg::LEN_POS) begin
				place_byte(pos, 8'h00);
				pos++;
			end
			block_buf[14] = len[63:32];
			block_buf[15] = len[31:0];
			compress();
			for (int i = 0; i < 5; i++) begin
				exp_word.digest_word = chain[i];
				exp_word.word_index = 3'(i);
				exp_word.last_word = (3'(i) == sha1_pkg::LAST_INDEX);
				digest_q.push_back(exp_word);
			end
			restart();
		endfunction

		function void check(digest_item_t got);
			digest_item_t exp_word;
			words_checked++;
			if (digest_q.size() == 0) begin
				$error("unexpected digest word %h index %0d", got.digest_word, got.word_index);
				mismatches++;
				return;
			end
			exp_word = digest_q.pop_front();
			if (got.digest_word !== exp_word.digest_word) begin
				$error("digest_word: expected %h, got %h", exp_word.digest_word, got.digest_word);
				mismatches++;
			end
			if (got.word_index !== exp_word.word_index) begin
				$error("word_index: expected %0d, got %0d", exp_word.word_index, got.word_index);
				mismatches++;
			end
			if (got.last_word !== exp_word.last_word) begin
				$error("last_word: expected %0d, got %0d", exp_word.last_word, got.last_word);
				mismatches++;
			end
			if (exp_word.last_word) digests_done++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	sha1_if #(.payload_t(msg_item_t)) in_ch (clk);
	sha1_if #(.payload_t(digest_item_t)) out_ch (clk);

	sha1_message_digest DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	sha1_scoreboard digest_board = new();
	int unsigned hold_cycles = 0;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned items_sent = 0;
	int unsigned messages_sent = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) digest_board.note_input(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready) digest_board.check(out_ch.data);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL sha1_message_digest");
			$finish;
		end
	end

	// The receiver steps through three stall patterns in turn; a long hold-off overrides them.
	initial begin
		int unsigned phase;
		out_ch.ready = 1'b0;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if (hold_cycles > 0) begin
				out_ch.ready = 1'b0;
				hold_cycles--;
			end else begin
				case ((phase / 64) % 3)
					0: begin
						out_ch.ready = 1'b1;
					end
					1: begin
						out_ch.ready = $urandom_range(1, 0);
					end
					default: begin
						out_ch.ready = ($urandom_range(3, 0) == 0);
					end
				endcase
			end
		end
	end

	// Ready is stable at the falling edge, so the word is taken at the next rising edge.
	task automatic send_word(input logic [7:0] val, input logic has, input logic fin);
		in_ch.valid = 1'b1;
		in_ch.data = '{data_byte: val, has_byte: has, last: fin};
		while (!in_ch.ready) @(negedge clk);
		@(negedge clk);
		if (has || fin) items_sent++;
		if (has) bytes_sent++;
		if (fin) messages_sent++;
	endtask

	task automatic idle_gap(input int unsigned cycles);
		in_ch.valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic send_message(input int unsigned len, input bit end_only);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(19, 0) == 0) send_word(8'($urandom_range(255, 0)), 1'b0, 1'b0);
			send_word(8'($urandom_range(255, 0)), 1'b1, !end_only && i == len - 1);
			if ($urandom_range(7, 0) == 0) idle_gap($urandom_range(6, 1));
		end
		if (end_only || len == 0) send_word(8'($urandom_range(255, 0)), 1'b0, 1'b1);
	endtask

	initial begin
		int unsigned len;
		int unsigned pick;
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty messages, idle words, one-byte message closed on its byte, "abc", 2-byte ones.
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b1);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h5A, 1'b0, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'hA5, 1'b0, 1'b1);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h01, 1'b1, 1'b1);
		send_word(8'h00, 1'b0, 1'b1);
		wait (digest_board.digest_q.size() == 0);
		@(negedge clk);

		while (items_sent < RANDOM_ITEMS + 13) begin
			pick = $urandom_range(9, 0);
			if (pick < 5) len = $urandom_range(8, 0);
			else if (pick < 9) len = $urandom_range(66, 52);
			else len = $urandom_range(130, 100);
			// A short message during the hold-off makes the digest back up into the input.
			if (!held && items_sent >= 120) begin
				held = 1'b1;
				hold_cycles = 400;
				len = $urandom_range(8, 0);
			end
			if (!paused && items_sent >= 220) begin
				paused = 1'b1;
				in_ch.valid = 1'b0;
				wait (digest_board.digest_q.size() == 0);
				@(negedge clk);
			end
			if (len > RANDOM_ITEMS + 13 - items_sent) len = RANDOM_ITEMS + 13 - items_sent;
			send_message(len, $urandom_range(3, 0) == 0);
			if ($urandom_range(2, 0) == 0) idle_gap($urandom_range(20, 1));
		end
		in_ch.valid = 1'b0;

		wait (digest_board.digest_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d messages (%0d bytes), %0d digests, %0d digest words checked.",
			messages_sent, bytes_sent, digest_board.digests_done, digest_board.words_checked);
		if (digest_board.mismatches == 0 && digest_board.digest_q.size() == 0) begin
			$display("PASS sha1_message_digest");
		end else begin
			$display("FAIL sha1_message_digest");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_if.sv
hw/rtl/sha1_datapath.sv
hw/rtl/sha1_control.sv
hw/rtl/sha1_message_digest.sv
tb/testbench.sv
